@@ rtl/ifas_pkg.sv @@
// ============================================================================
// ifas_pkg: shared types and constants of the idle face animation sequencer
// Beat payloads, mode and animation codes, timing constants, the logarithmic
// backlight table with the small helpers built on it, and the face-change test.
// ============================================================================
package ifas_pkg;

   // Request beat: one tick or event
   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] now_ms;
      logic [7:0]  expression;
      logic [3:0]  pick_draw;
      logic [15:0] gap_draw;
   } req_type;

   // Response beat: one per request
   typedef struct packed {
      logic       pwm_write;
      logic [7:0] pwm_value;
      logic       show_write;
      logic [3:0] show_sprite;
      logic       idle_running;
   } rsp_type;

   // Sine pulse still to be worked out for this beat
   typedef struct packed {
      logic        active;
      logic        drift;
      logic [31:0] elapsed;
      logic [7:0]  lo;
      logic [7:0]  span;
   } pulse_ctrl_type;

   typedef struct packed {
      rsp_type        rsp;
      pulse_ctrl_type pulse;
   } step_out_type;

   // Request modes
   localparam logic [2:0] MODE_TICK  = 3'd0;
   localparam logic [2:0] MODE_SHOW  = 3'd1;
   localparam logic [2:0] MODE_START = 3'd2;
   localparam logic [2:0] MODE_STOP  = 3'd3;
   localparam logic [2:0] MODE_GREET = 3'd4;

   // Animation codes
   localparam logic [3:0] ANIM_BREATHE = 4'd0;
   localparam logic [3:0] ANIM_DRIFT   = 4'd1;
   localparam logic [3:0] ANIM_TWITCH  = 4'd2;
   localparam logic [3:0] ANIM_BLINK   = 4'd3;
   localparam logic [3:0] ANIM_YAWN    = 4'd4;
   localparam logic [3:0] ANIM_SMIRK   = 4'd5;
   localparam logic [3:0] ANIM_WAG     = 4'd6;
   localparam logic [3:0] ANIM_BOING   = 4'd7;
   localparam logic [3:0] ANIM_NONE    = 4'd15;

   // Faces and sprites
   localparam logic [3:0] FACE_NEUTRAL   = 4'd0;
   localparam logic [3:0] FACE_SQUINT    = 4'd2;
   localparam logic [3:0] FACE_SURPRISE  = 4'd5;
   localparam logic [3:0] FACE_SILLY     = 4'd9;
   localparam logic [3:0] FACE_TONGUE_IN = 4'd10;
   localparam logic [7:0] FACE_MAX       = 8'd9;

   // Timing, in milliseconds
   localparam logic [12:0] BREATHE_PERIOD = 13'd4000;
   localparam logic [12:0] DRIFT_PERIOD   = 13'd6000;
   localparam logic [31:0] BREATHE_LEN    = 32'd45000;
   localparam logic [31:0] DRIFT_LEN      = 32'd20000;
   localparam logic [31:0] TWITCH_LEN     = 32'd400;
   localparam logic [31:0] BLINK_LEN      = 32'd150;
   localparam logic [31:0] YAWN_LEN       = 32'd600;
   localparam logic [31:0] SMIRK_LEN      = 32'd800;
   localparam logic [31:0] BOING_FLIP     = 32'd300;
   localparam logic [31:0] BOING_LEN      = 32'd600;
   localparam logic [31:0] GAP_BASE       = 32'd20000;
   localparam logic [15:0] GAP_DRAW_MAX   = 16'd39999;
   localparam logic [31:0] FIRST_DELAY    = 32'd5000;
   localparam logic [31:0] SILLY_DELAY    = 32'd2000;

   // Tongue wag: half-cycles of 300 ms, saturating at 255 (255 * 300 + 300 ms)
   localparam logic [31:0] WAG_SAT_EL    = 32'd76800;
   localparam logic [17:0] WAG_RECIP     = 18'd223697;   // ceil(2^26 / 300)
   localparam int          WAG_SHIFT     = 26;
   localparam logic [7:0]  WAG_LAST_HALF = 8'd6;

   // Pulse period quotient: el/4000 = (el>>5)/125, el/6000 = (el>>4)/375
   localparam logic [28:0] BREATHE_DIV_RECIP = 29'd137438954;  // ceil(2^34 / 125)
   localparam int          BREATHE_DIV_SHIFT = 34;
   localparam logic [28:0] DRIFT_DIV_RECIP   = 29'd366503876;  // ceil(2^37 / 375)
   localparam int          DRIFT_DIV_SHIFT   = 37;

   localparam logic [7:0] BL_MAP [16] = '{
      8'd0, 8'd2, 8'd4, 8'd7, 8'd11, 8'd16, 8'd22, 8'd30,
      8'd40, 8'd55, 8'd75, 8'd100, 8'd135, 8'd175, 8'd210, 8'd255
   };

   function automatic logic [7:0] bl_map(input logic [3:0] level);
      return BL_MAP[level];
   endfunction

   // Level raised by a small step, held at the top of the table
   function automatic logic [3:0] bl_step_up(input logic [3:0] level, input logic [1:0] step);
      logic [4:0] sum;
      sum = {1'b0, level} + {3'b000, step};
      return (sum > 5'd15) ? 4'd15 : sum[3:0];
   endfunction

   // Level lowered by two, held at the bottom of the table
   function automatic logic [3:0] bl_step_down2(input logic [3:0] level);
      return (level < 4'd2) ? 4'd0 : level - 4'd2;
   endfunction

   function automatic logic face_changing(input logic [3:0] anim);
      return (anim == ANIM_TWITCH) || (anim == ANIM_YAWN) || (anim == ANIM_SMIRK) ||
             (anim == ANIM_WAG) || (anim == ANIM_BOING);
   endfunction

endpackage

@@ rtl/ifas_sine_rom.sv @@
// ============================================================================
// ifas_sine_rom: Q0.8 sine table for the backlight pulses
// Entries are built at elaboration from a rational sine approximation; the
// read is combinational.
// ============================================================================
module ifas_sine_rom #(
   parameter int SINE_ENTRIES = 256
) (
   input  logic [$clog2(SINE_ENTRIES)-1:0] pos,
   output logic [7:0]                      entry
);

   localparam int PW        = $clog2(SINE_ENTRIES);
   localparam int LUT_DEPTH = 2 ** PW;

   logic [7:0] sine_lut [LUT_DEPTH];

   for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_lut
      localparam longint N_E   = SINE_ENTRIES;
      localparam longint M2    = 2 * i;
      localparam bit     NEG   = (M2 >= N_E);
      localparam longint M0    = NEG ? M2 - N_E : M2;
      localparam longint M     = (M0 > N_E) ? N_E : M0;
      localparam longint U     = M * (N_E - M);
      localparam longint DEN0  = 5 * N_E * N_E - 4 * U;
      localparam longint DEN   = (DEN0 == 0) ? 1 : DEN0;
      localparam longint MAG0  = (2048 * U + DEN / 2) / DEN;
      localparam longint MAG   = (MAG0 > 128) ? 128 : MAG0;
      localparam longint R0    = NEG ? 128 - MAG : 128 + MAG;
      localparam longint R     = (R0 > 255) ? 255 : R0;
      if (i < SINE_ENTRIES) begin : g_used
         assign sine_lut[i] = 8'(R);
      end else begin : g_spare
         // unreachable codes: mid-scale
         assign sine_lut[i] = 8'd128;
      end
   end

   assign entry = sine_lut[pos];

endmodule

@@ rtl/ifas_pulse.sv @@
// ============================================================================
// ifas_pulse: sine pulse datapath and response register
// Five pipeline stages turn elapsed time into a PWM duty; beats without a
// pulse pass through unchanged. Each stage loads whenever it is empty or
// its content moves on.
// ============================================================================
module ifas_pulse import ifas_pkg::*; #(
   parameter int SINE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  step_out_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_type      out_data
);

   localparam int PW        = $clog2(SINE_ENTRIES);
   localparam int RW        = PW + 15;
   localparam int POS_SHIFT = 26;
   localparam longint unsigned POS_RECIP_BREATHE =
      ((64'(SINE_ENTRIES) << POS_SHIFT) + 64'(BREATHE_PERIOD) - 64'd1) / BREATHE_PERIOD;
   localparam longint unsigned POS_RECIP_DRIFT =
      ((64'(SINE_ENTRIES) << POS_SHIFT) + 64'(DRIFT_PERIOD) - 64'd1) / DRIFT_PERIOD;

   // stage registers
   logic           v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, out_valid_ff;
   step_out_type   s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   logic [20:0]    quot_ff;
   logic [12:0]    rem_ff;
   logic [PW-1:0]  pos_ff;
   logic [7:0]     entry_ff;
   rsp_type        out_ff;

   logic           en1, en2, en3, en4, en5, en_out;
   logic [27:0]    div_x;
   logic [28:0]    div_k;
   logic [56:0]    div_prod;
   logic [20:0]    quot_in;
   logic [12:0]    period;
   logic [33:0]    back_prod;
   logic [31:0]    rem_full;
   logic [12:0]    rem_in;
   logic [RW-1:0]  pos_k;
   logic [RW+12:0] pos_prod;
   logic [PW-1:0]  pos_in;
   logic [7:0]     entry_in;
   logic [15:0]    duty_prod;
   rsp_type        out_in;

   assign en_out   = !out_valid_ff || out_ready;
   assign en5      = !v5_ff || en_out;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 2: period quotient by reciprocal
   assign div_x    = s1_ff.pulse.drift ? 28'(s1_ff.pulse.elapsed >> 4)
                                       : 28'(s1_ff.pulse.elapsed >> 5);
   assign div_k    = s1_ff.pulse.drift ? DRIFT_DIV_RECIP : BREATHE_DIV_RECIP;
   assign div_prod = 57'(div_x) * 57'(div_k);
   assign quot_in  = s1_ff.pulse.drift ? 21'(div_prod >> DRIFT_DIV_SHIFT)
                                       : 21'(div_prod >> BREATHE_DIV_SHIFT);

   // stage 3: remainder within the period
   assign period    = s2_ff.pulse.drift ? DRIFT_PERIOD : BREATHE_PERIOD;
   assign back_prod = 34'(quot_ff) * 34'(period);
   assign rem_full  = s2_ff.pulse.elapsed - back_prod[31:0];
   assign rem_in    = rem_full[12:0];

   // stage 4: table position, rem * entries / period
   assign pos_k    = s3_ff.pulse.drift ? RW'(POS_RECIP_DRIFT) : RW'(POS_RECIP_BREATHE);
   assign pos_prod = (RW+13)'(rem_ff) * (RW+13)'(pos_k);
   assign pos_in   = PW'(pos_prod >> POS_SHIFT);

   // stage 5: table read
   ifas_sine_rom #(
      .SINE_ENTRIES(SINE_ENTRIES)
   ) u_ifas_sine_rom (
      .pos  (pos_ff),
      .entry(entry_in)
   );

   // response: lo + entry * span / 256
   assign duty_prod = 16'(entry_ff) * 16'(s5_ff.pulse.span);
   always_comb begin
      out_in = s5_ff.rsp;
      if (s5_ff.pulse.active) begin
         out_in.pwm_value = s5_ff.pulse.lo + duty_prod[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= in_valid;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en5)    v5_ff        <= v4_ff;
         if (en_out) out_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= in_data;
      end
      if (en2) begin
         s2_ff   <= s1_ff;
         quot_ff <= quot_in;
      end
      if (en3) begin
         s3_ff  <= s2_ff;
         rem_ff <= rem_in;
      end
      if (en4) begin
         s4_ff  <= s3_ff;
         pos_ff <= pos_in;
      end
      if (en5) begin
         s5_ff    <= s4_ff;
         entry_ff <= entry_in;
      end
      if (en_out) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

@@ rtl/ifas_step.sv @@
// ============================================================================
// ifas_step: sequencer state and one-beat step logic
// Holds the idle engine state and the backlight level, and works out the
// state after a beat together with its writes and any pulse still to do.
// ============================================================================
module ifas_step import ifas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [3:0]   csr_data,
   input  logic         item_go,
   input  req_type      item,
   output step_out_type result
);

   logic        idle_on_ff,      idle_on_in;
   logic [3:0]  running_anim_ff, running_anim_in;
   logic [7:0]  anim_phase_ff,   anim_phase_in;
   logic [31:0] phase_start_ff,  phase_start_in;
   logic [31:0] next_start_ff,   next_start_in;
   logic [3:0]  saved_face_ff,   saved_face_in;
   logic [3:0]  shown_face_ff,   shown_face_in;
   logic [31:0] silly_time_ff,   silly_time_in;
   logic [3:0]  backlight_level_ff;

   logic [31:0] el;
   logic [15:0] gap;
   logic [34:0] wag_prod;
   logic [7:0]  half;
   logic [7:0]  hi_duty, breathe_lo, drift_lo;
   logic [3:0]  pick_anim;
   logic        show_req;
   logic [3:0]  show_face;
   logic        finish;
   logic        boing_hit;
   step_out_type res;

   assign el         = item.now_ms - phase_start_ff;
   assign gap        = (item.gap_draw > GAP_DRAW_MAX) ? GAP_DRAW_MAX : item.gap_draw;
   assign wag_prod   = 35'(el[16:0]) * 35'(WAG_RECIP);
   assign half       = (el >= WAG_SAT_EL) ? 8'hFF : wag_prod[WAG_SHIFT+7:WAG_SHIFT];
   assign hi_duty    = bl_map(backlight_level_ff);
   assign breathe_lo = bl_map(4'd2);
   assign drift_lo   = bl_map(bl_step_down2(backlight_level_ff));

   always_comb begin
      priority if (item.pick_draw < 4'd2)  pick_anim = ANIM_BREATHE;
      else if (item.pick_draw < 4'd4)      pick_anim = ANIM_BLINK;
      else if (item.pick_draw < 4'd6)      pick_anim = ANIM_TWITCH;
      else if (item.pick_draw < 4'd8)      pick_anim = ANIM_SMIRK;
      else if (item.pick_draw < 4'd9)      pick_anim = ANIM_DRIFT;
      else if (item.pick_draw < 4'd10)     pick_anim = ANIM_YAWN;
      else                                 pick_anim = ANIM_BOING;
   end

   always_comb begin
      idle_on_in      = idle_on_ff;
      running_anim_in = running_anim_ff;
      anim_phase_in   = anim_phase_ff;
      phase_start_in  = phase_start_ff;
      next_start_in   = next_start_ff;
      saved_face_in   = saved_face_ff;
      shown_face_in   = shown_face_ff;
      silly_time_in   = silly_time_ff;
      res             = '0;
      show_req        = 1'b0;
      show_face       = FACE_NEUTRAL;
      finish          = 1'b0;
      boing_hit       = 1'b0;

      unique case (item.mode)
         MODE_TICK: begin
            if (idle_on_ff) begin
               if (running_anim_ff == ANIM_NONE) begin
                  if (shown_face_ff == FACE_SILLY && silly_time_ff != 32'd0 &&
                      (item.now_ms - silly_time_ff) >= SILLY_DELAY) begin
                     running_anim_in = ANIM_WAG;
                     anim_phase_in   = 8'd0;
                     phase_start_in  = item.now_ms;
                     saved_face_in   = FACE_SILLY;
                     silly_time_in   = 32'd0;
                  end else if (item.now_ms >= next_start_ff) begin
                     running_anim_in = pick_anim;
                     anim_phase_in   = 8'd0;
                     phase_start_in  = item.now_ms;
                     saved_face_in   = shown_face_ff;
                     unique case (pick_anim)
                        ANIM_TWITCH: begin
                           show_req  = 1'b1;
                           show_face = FACE_SQUINT;
                        end
                        ANIM_SMIRK: begin
                           show_req          = 1'b1;
                           show_face         = FACE_SQUINT;
                           res.rsp.pwm_write = 1'b1;
                           res.rsp.pwm_value = bl_map(bl_step_up(backlight_level_ff, 2'd2));
                        end
                        ANIM_YAWN, ANIM_BOING: begin
                           show_req          = 1'b1;
                           show_face         = FACE_SURPRISE;
                           res.rsp.pwm_write = 1'b1;
                           res.rsp.pwm_value = bl_map(bl_step_up(backlight_level_ff, 2'd3));
                        end
                        default: begin
                        end
                     endcase
                  end
               end else begin
                  unique case (running_anim_ff)
                     ANIM_BREATHE: begin
                        res.rsp.pwm_write  = 1'b1;
                        res.pulse.active   = 1'b1;
                        res.pulse.drift    = 1'b0;
                        res.pulse.elapsed  = el;
                        res.pulse.lo       = breathe_lo;
                        res.pulse.span     = (hi_duty > breathe_lo) ? hi_duty - breathe_lo : 8'd0;
                        finish             = (el >= BREATHE_LEN);
                     end
                     ANIM_DRIFT: begin
                        res.rsp.pwm_write  = 1'b1;
                        res.pulse.active   = 1'b1;
                        res.pulse.drift    = 1'b1;
                        res.pulse.elapsed  = el;
                        res.pulse.lo       = drift_lo;
                        res.pulse.span     = (hi_duty > drift_lo) ? hi_duty - drift_lo : 8'd0;
                        finish             = (el >= DRIFT_LEN);
                     end
                     ANIM_TWITCH: finish = (el >= TWITCH_LEN);
                     ANIM_BLINK: begin
                        if (anim_phase_ff == 8'd0) begin
                           res.rsp.pwm_write = 1'b1;
                           res.rsp.pwm_value = 8'd0;
                           anim_phase_in     = 8'd1;
                        end
                        finish = (el >= BLINK_LEN);
                     end
                     ANIM_YAWN:  finish = (el >= YAWN_LEN);
                     ANIM_SMIRK: finish = (el >= SMIRK_LEN);
                     ANIM_WAG: begin
                        if (half != anim_phase_ff) begin
                           anim_phase_in = half;
                           if (half >= WAG_LAST_HALF) begin
                              finish = 1'b1;
                           end else begin
                              res.rsp.show_write  = 1'b1;
                              res.rsp.show_sprite = half[0] ? FACE_TONGUE_IN : FACE_SILLY;
                           end
                        end
                     end
                     ANIM_BOING: begin
                        boing_hit = (anim_phase_ff == 8'd0) && (el >= BOING_FLIP);
                        if (boing_hit) begin
                           show_req          = 1'b1;
                           show_face         = FACE_NEUTRAL;
                           res.rsp.pwm_write = 1'b1;
                           res.rsp.pwm_value = hi_duty;
                           anim_phase_in     = 8'd1;
                        end
                        finish = (anim_phase_ff != 8'd0 || boing_hit) && (el >= BOING_LEN);
                     end
                     default: begin
                     end
                  endcase
                  // wind down: restore backlight and, where changed, the face; schedule the next one
                  if (finish) begin
                     running_anim_in   = ANIM_NONE;
                     anim_phase_in     = 8'd0;
                     res.rsp.pwm_write = 1'b1;
                     res.rsp.pwm_value = hi_duty;
                     res.pulse.active  = 1'b0;
                     if (face_changing(running_anim_ff)) begin
                        show_req  = 1'b1;
                        show_face = saved_face_ff;
                     end
                     next_start_in = item.now_ms + GAP_BASE + 32'(gap);
                  end
               end
            end
         end
         MODE_SHOW: begin
            show_req  = 1'b1;
            show_face = (item.expression > FACE_MAX) ? FACE_NEUTRAL : item.expression[3:0];
         end
         MODE_START: begin
            if (!idle_on_ff) begin
               idle_on_in      = 1'b1;
               running_anim_in = ANIM_NONE;
               next_start_in   = item.now_ms + FIRST_DELAY;
            end
         end
         MODE_STOP: begin
            if (idle_on_ff) begin
               idle_on_in = 1'b0;
               if (running_anim_ff != ANIM_NONE) begin
                  running_anim_in   = ANIM_NONE;
                  anim_phase_in     = 8'd0;
                  res.rsp.pwm_write = 1'b1;
                  res.rsp.pwm_value = hi_duty;
                  if (face_changing(running_anim_ff)) begin
                     show_req  = 1'b1;
                     show_face = saved_face_ff;
                  end
               end
            end
         end
         MODE_GREET: begin
            if (idle_on_ff && running_anim_ff == ANIM_NONE) begin
               saved_face_in     = shown_face_ff;
               running_anim_in   = ANIM_BOING;
               anim_phase_in     = 8'd0;
               phase_start_in    = item.now_ms;
               show_req          = 1'b1;
               show_face         = FACE_SURPRISE;
               res.rsp.pwm_write = 1'b1;
               res.rsp.pwm_value = bl_map(bl_step_up(backlight_level_ff, 2'd3));
            end
         end
         default: begin
         end
      endcase

      // face change: the silly face arms the wag timer and wakes the engine
      if (show_req) begin
         shown_face_in       = show_face;
         res.rsp.show_write  = 1'b1;
         res.rsp.show_sprite = show_face;
         if (show_face == FACE_SILLY) begin
            silly_time_in = item.now_ms;
            if (!idle_on_in) begin
               idle_on_in      = 1'b1;
               running_anim_in = ANIM_NONE;
               next_start_in   = item.now_ms + FIRST_DELAY;
            end
         end
      end

      res.rsp.idle_running = idle_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_on_ff         <= 1'b0;
         running_anim_ff    <= ANIM_NONE;
         anim_phase_ff      <= 8'd0;
         phase_start_ff     <= 32'd0;
         next_start_ff      <= 32'd0;
         saved_face_ff      <= FACE_NEUTRAL;
         shown_face_ff      <= FACE_NEUTRAL;
         silly_time_ff      <= 32'd0;
         backlight_level_ff <= 4'd14;
      end else begin
         if (item_go) begin
            idle_on_ff      <= idle_on_in;
            running_anim_ff <= running_anim_in;
            anim_phase_ff   <= anim_phase_in;
            phase_start_ff  <= phase_start_in;
            next_start_ff   <= next_start_in;
            saved_face_ff   <= saved_face_in;
            shown_face_ff   <= shown_face_in;
            silly_time_ff   <= silly_time_in;
         end
         if (csr_write) begin
            backlight_level_ff <= csr_data;
         end
      end
   end

   assign result = res;

endmodule

@@ rtl/idle_face_animation_sequencer.sv @@
// ============================================================================
// idle_face_animation_sequencer: idle animation engine for a display face
// Turns ticks and face events into backlight PWM writes and sprite choices.
// ============================================================================
// One response beat comes back for every request beat, in order. The block
// takes a request every cycle while the response side does not stall, and
// returns its response through the state step out of the input register and
// then the sine pulse datapath (period quotient, remainder, table position,
// table read, duty) into the response register. A request may follow the
// previous one at once; a stalled response side fills the stages in turn
// before req_ready drops. Breathe and drift pulses read a sine table of
// SINE_ENTRIES entries in Q0.8. The backlight level register is written
// through the csr channel, which is always ready; write it only while no
// request is in flight.
module idle_face_animation_sequencer import ifas_pkg::*; #(
   parameter int SINE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_item,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   // input register
   logic         in_valid_ff;
   req_type      in_item_ff;
   logic         step_go;
   logic         pulse_ready;
   step_out_type step_result;

   // advance the held beat once the pulse datapath can take it
   assign step_go   = in_valid_ff && pulse_ready;
   assign req_ready = !in_valid_ff || step_go;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // hold the payload until the beat is stepped
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // state step: every state change of a beat happens here
   ifas_step u_ifas_step (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_valid && csr_ready),
      .csr_data (csr_data),
      .item_go  (step_go),
      .item     (in_item_ff),
      .result   (step_result)
   );

   // pulse datapath and response register
   ifas_pulse #(
      .SINE_ENTRIES(SINE_ENTRIES)
   ) u_ifas_pulse (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_ready (pulse_ready),
      .in_data  (step_result),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (rsp_item)
   );

endmodule

@@ rtl/ifas_checker.sv @@
// ============================================================================
// ifas_checker: port-level checks for the idle face animation sequencer
// Watches the response channel over time; bound to the top level.
// ============================================================================
module ifas_checker import ifas_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input rsp_type    rsp_item
);

   // nothing may come out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_pwm_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.pwm_write |-> rsp_item.pwm_value == 8'd0)
      else $error("pwm value set without a pwm write");

   a_show_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.show_write |-> rsp_item.show_sprite == FACE_NEUTRAL)
      else $error("sprite set without a show write");

   a_sprite_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.show_write |-> rsp_item.show_sprite <= FACE_TONGUE_IN)
      else $error("sprite code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled response beat changed");

endmodule

bind idle_face_animation_sequencer ifas_checker u_ifas_checker (.*);
